// File: hdl/multi_queue_linked_fifo_assert.svh
// Assertion macros for the multi_queue_linked_fifo RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef MULTI_QUEUE_LINKED_FIFO_ASSERT_SVH
`define MULTI_QUEUE_LINKED_FIFO_ASSERT_SVH

// Check under clock, masked while reset is asserted.
`define MQLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check under clock, also sampled during reset.
`define MQLF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mqlf_pkg.sv
// Shared types and constants for the multi-queue linked FIFO.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mqlf_pkg;

  localparam int NUM_QUEUES_DEF = 16;
  localparam int POOL_SIZE_DEF  = 256;

  localparam int DATA_W = 32;
  localparam int QID_W  = 4;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic signed [DATA_W-1:0] EMPTY_KEY = -32'sd42069;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: hdl/mqlf_node_mem.sv
// Node pool storage: key memory and link memory, registered reads.
// Link entries not yet written read as the reset free-list chain. Uses mqlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mqlf_node_mem
  import mqlf_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF,
  parameter int NODE_W    = $clog2(POOL_SIZE_DEF)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic        [NODE_W-1:0] rd_addr,
  input  wire logic                     val_wr_en,
  input  wire logic        [NODE_W-1:0] val_wr_addr,
  input  wire logic signed [DATA_W-1:0] val_wr_data,
  input  wire logic                     nxt_wr_en,
  input  wire logic        [NODE_W-1:0] nxt_wr_addr,
  input  wire logic        [NODE_W-1:0] nxt_wr_data,
  output logic signed      [DATA_W-1:0] rd_value,
  output logic             [NODE_W-1:0] rd_next
);

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(POOL_SIZE - 1);

  logic signed [DATA_W-1:0] value_mem [POOL_SIZE];
  logic        [NODE_W-1:0] next_mem  [POOL_SIZE];
  logic     [POOL_SIZE-1:0] linked_r;

  logic signed [DATA_W-1:0] value_q_r;
  logic        [NODE_W-1:0] next_q_r;
  logic        [NODE_W-1:0] addr_q_r;
  logic                     linked_q_r;

  always_ff @(posedge clk) begin
    if (val_wr_en) begin
      value_mem[val_wr_addr] <= val_wr_data;
    end
    if (rd_en) begin
      value_q_r <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_wr_en) begin
      next_mem[nxt_wr_addr] <= nxt_wr_data;
    end
    if (rd_en) begin
      next_q_r   <= next_mem[rd_addr];
      linked_q_r <= linked_r[rd_addr];
      addr_q_r   <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linked_r <= '0;
    end else if (nxt_wr_en) begin
      linked_r[nxt_wr_addr] <= 1'b1;
    end
  end

  assign rd_value = value_q_r;

  always_comb begin
    if (linked_q_r) begin
      rd_next = next_q_r;
    end else if (addr_q_r == LAST_NODE) begin
      rd_next = '0;
    end else begin
      rd_next = addr_q_r + NODE_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/multi_queue_linked_fifo.sv
// Several FIFO queues sharing one pool of linked nodes.
// Input channel in_*: op (0 enqueue, 1 dequeue), queue_id, value.
// Result channel out_*: status (ok, empty, full, bad id) and data_out, one per item.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// The accept issues the node memory read (the free head for an enqueue, the
// queue head for a dequeue); in S_EXEC the block then uses the registered key
// and link, writes back and loads the result register. in_stall is high while
// an item is in flight, so a new item is taken only after the last one
// finishes. out_valid is registered and rises when the result register loads.
// The result register holds a finished item while out_stall is high; the block
// still accepts the next item, which then waits in S_EXEC until the
// result register frees.
// Reset (rst_n low, synchronous) empties every queue, chains all nodes into the
// free list and drops any pending result. No clearing pass: the block accepts
// items from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_queue_linked_fifo_assert.svh"

module multi_queue_linked_fifo
  import mqlf_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int POOL_SIZE  = POOL_SIZE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_op,
  input  wire logic        [QID_W-1:0]  in_queue_id,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic             [1:0]        out_status,
  output logic signed      [DATA_W-1:0] out_data_out
);

  localparam int NODE_W = $clog2(POOL_SIZE);
  localparam int CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int QIX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SIZE);
  localparam logic [QID_W:0]   NQ_LIM   = (QID_W + 1)'(NUM_QUEUES);

  state_t state_r, state_nxt;

  logic                     op_r;
  logic        [QID_W-1:0]  qid_r;
  logic signed [DATA_W-1:0] value_r;

  logic [NODE_W-1:0]     head_r [NUM_QUEUES];
  logic [NODE_W-1:0]     tail_r [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty_r;
  logic [NODE_W-1:0]     free_head_r, free_head_nxt;
  logic [CNT_W-1:0]      free_count_r, free_count_nxt;

  logic                     out_valid_r;
  status_t                  out_status_r, status_nxt;
  logic signed [DATA_W-1:0] out_data_r, data_nxt;

  logic                     in_accept;
  logic                     exec_done;
  logic                     in_id_ok;
  logic [QIX_W-1:0]         in_q;
  logic [NODE_W-1:0]        rd_addr;
  logic signed [DATA_W-1:0] rd_value;
  logic [NODE_W-1:0]        rd_next;

  logic              id_ok;
  logic [QIX_W-1:0]  q;
  logic [NODE_W-1:0] cur_head, cur_tail, head_nxt, tail_nxt;
  logic              cur_ne, ne_nxt, q_upd;
  logic              val_wr, nxt_wr;
  logic [NODE_W-1:0] nxt_wr_addr, nxt_wr_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign in_q     = in_queue_id[QIX_W-1:0];
  assign in_id_ok = {1'b0, in_queue_id} < NQ_LIM;
  assign rd_addr  = (in_op == OP_DEQ && in_id_ok) ? head_r[in_q] : free_head_r;

  mqlf_node_mem #(
    .POOL_SIZE (POOL_SIZE),
    .NODE_W    (NODE_W)
  ) u_node_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_accept),
    .rd_addr     (rd_addr),
    .val_wr_en   (val_wr && exec_done),
    .val_wr_addr (free_head_r),
    .val_wr_data (value_r),
    .nxt_wr_en   (nxt_wr && exec_done),
    .nxt_wr_addr (nxt_wr_addr),
    .nxt_wr_data (nxt_wr_data),
    .rd_value    (rd_value),
    .rd_next     (rd_next)
  );

  assign q        = qid_r[QIX_W-1:0];
  assign id_ok    = {1'b0, qid_r} < NQ_LIM;
  assign cur_head = head_r[q];
  assign cur_tail = tail_r[q];
  assign cur_ne   = nonempty_r[q];

  always_comb begin
    status_nxt     = ST_OK;
    data_nxt       = '0;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    head_nxt       = cur_head;
    tail_nxt       = cur_tail;
    ne_nxt         = cur_ne;
    q_upd          = 1'b0;
    val_wr         = 1'b0;
    nxt_wr         = 1'b0;
    nxt_wr_addr    = cur_tail;
    nxt_wr_data    = free_head_r;
    priority if (!id_ok) begin
      status_nxt = ST_BADID;
    end else if (op_r == OP_ENQ) begin
      if (free_count_r == '0) begin
        status_nxt = ST_FULL;
      end else begin
        free_head_nxt  = rd_next;
        free_count_nxt = free_count_r - CNT_W'(1);
        val_wr         = 1'b1;
        if (!cur_ne) begin
          head_nxt = free_head_r;
          ne_nxt   = 1'b1;
        end else begin
          nxt_wr      = 1'b1;
          nxt_wr_addr = cur_tail;
          nxt_wr_data = free_head_r;
        end
        tail_nxt = free_head_r;
        q_upd    = 1'b1;
      end
    end else begin
      if (!cur_ne) begin
        status_nxt = ST_EMPTY;
        data_nxt   = EMPTY_KEY;
      end else begin
        data_nxt = rd_value;
        if (cur_head == cur_tail) begin
          ne_nxt = 1'b0;
        end else begin
          head_nxt = rd_next;
        end
        nxt_wr        = 1'b1;
        nxt_wr_addr   = cur_head;
        nxt_wr_data   = free_head_r;
        free_head_nxt = cur_head;
        if (free_count_r < CNT_FULL) begin
          free_count_nxt = free_count_r + CNT_W'(1);
        end
        q_upd = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_op;
      qid_r   <= in_queue_id;
      value_r <= in_value;
    end
    if (exec_done) begin
      out_status_r <= status_nxt;
      out_data_r   <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_head_r  <= '0;
      free_count_r <= CNT_FULL;
      nonempty_r   <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (exec_done) begin
        free_head_r  <= free_head_nxt;
        free_count_r <= free_count_nxt;
      end
      if (exec_done && q_upd) begin
        head_r[q]     <= head_nxt;
        tail_r[q]     <= tail_nxt;
        nonempty_r[q] <= ne_nxt;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;

  `MQLF_ASSERT(a_count_range, free_count_r <= CNT_FULL, "free count above pool size")
  `MQLF_ASSERT(a_all_free_empty, (free_count_r == CNT_FULL) |-> (nonempty_r == '0), "queue holds nodes while pool is all free")
  `MQLF_ASSERT(a_accept_exec, in_accept |=> (state_r == S_EXEC), "accepted item did not enter execution")
  `MQLF_ASSERT(a_done_result, exec_done |=> out_valid_r, "finished item gave no result")
  `MQLF_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "block not idle after reset")

endmodule

`default_nettype wire
